// ===== rtl/core/ramped_gain_mix_matrix_defines.svh =====
// Assertion macros for the ramped gain mix matrix
`ifndef RAMPED_GAIN_MIX_MATRIX_DEFINES_SVH
`define RAMPED_GAIN_MIX_MATRIX_DEFINES_SVH
`ifndef SYNTHESIS
`define RGMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgmm check failed");
`define RGMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgmm check failed");
`else
`define RGMM_ASSERT_IMP(lbl, ante, cons)
`define RGMM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/rgmm_pkg.sv =====
// Shared types and constants of the ramped gain mix matrix
`default_nettype none
package rgmm_pkg;

  localparam int IN_CHANNELS_DEF  = 8;
  localparam int OUT_CHANNELS_DEF = 8;
  localparam int RESULT_CAP       = 8;
  localparam int DIV_BITS         = 34;

  localparam logic [1:0] CMD_GAIN   = 2'd0;
  localparam logic [1:0] CMD_LEVEL  = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [15:0] RAMP_STEPS_RST = 16'd2400;
  localparam logic [17:0] LEVEL_TGT_RST  = 18'd65536;
  localparam logic [33:0] LEVEL_CUR_RST  = 34'h1_0000_0000;

  localparam int REG_GAIN_STEPS  = 0;
  localparam int REG_LEVEL_STEPS = 1;

  typedef struct packed {
    logic [17:0]        tgt;
    logic [33:0]        cur;
    logic signed [33:0] step;
    logic [15:0]        cnt;
  } rgmm_xp_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_G_CHK, ST_G_DIV, ST_L_CHK, ST_L_DIV,
    ST_S_RD, ST_S_ADV, ST_S_ACC, ST_F_LVL, ST_F_RD, ST_F_MUL, ST_F_SUM
  } rgmm_state_t;

  typedef struct packed {
    logic latch;
    logic cnt_clr;
    logic cnt_inc;
    logic clr_wr;
    logic g_imm;
    logic g_div;
    logic l_imm;
    logic l_div;
    logic div_start;
    logic s_adv;
    logic s_acc;
    logic l_adv;
    logic f_mul;
    logic f_out;
  } rgmm_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic fend;
    logic xp_ok;
    logic ich_ok;
    logic same_g;
    logic same_l;
    logic zero_g;
    logic zero_l;
    logic div_done;
    logic clr_last;
    logic out_last;
    logic emit;
    logic out_free;
  } rgmm_st_t;

endpackage
`default_nettype wire

// ===== rtl/core/rgmm_if.sv =====
// Input and result channel interfaces
`default_nettype none
interface rgmm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [2:0]         in_channel;
  logic [2:0]         out_channel;
  logic [17:0]        gain_value;
  logic signed [23:0] sample_in;
  logic               frame_end;
  modport source (output valid, command, in_channel, out_channel, gain_value,
                  sample_in, frame_end, input ready);
  modport sink (input valid, command, in_channel, out_channel, gain_value,
                sample_in, frame_end, output ready);
endinterface

interface rgmm_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         dest_channel;
  logic signed [23:0] sample_out;
  logic               last_of_frame;
  modport source (output valid, dest_channel, sample_out, last_of_frame, input ready);
  modport sink (input valid, dest_channel, sample_out, last_of_frame, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rgmm_ram.sv =====
// Generic single-write, registered-read RAM
`default_nettype none
module rgmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== rtl/core/rgmm_div.sv =====
// Restoring divider, one quotient bit per cycle
`default_nettype none
module rgmm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [33:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic      [33:0] quotient
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [33:0] quo_r, quo_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [16:0] sh;
  logic        ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    sh       = {rem_r, quo_r[33]};
    ge       = sh >= {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(rgmm_pkg::DIV_BITS - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 16'(sh - {1'b0, dvs_r}) : sh[15:0];
      quo_nxt = {quo_r[32:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

// ===== rtl/core/rgmm_dp.sv =====
// Datapath: crosspoint store, accumulators, level ramp, multipliers, result register
`default_nettype none
module rgmm_dp #(
  parameter int IN_CHANNELS  = rgmm_pkg::IN_CHANNELS_DEF,
  parameter int OUT_CHANNELS = rgmm_pkg::OUT_CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rgmm_pkg::rgmm_ctl_t ctl,
  output rgmm_pkg::rgmm_st_t      st,
  input  wire logic [1:0]         i_command,
  input  wire logic [2:0]         i_in_channel,
  input  wire logic [2:0]         i_out_channel,
  input  wire logic [17:0]        i_gain_value,
  input  wire logic signed [23:0] i_sample_in,
  input  wire logic               i_frame_end,
  input  wire logic [15:0]        gain_steps,
  input  wire logic [15:0]        level_steps,
  output logic                    o_valid,
  input  wire logic               o_ready,
  output logic [2:0]              o_dest_channel,
  output logic signed [23:0]      o_sample_out,
  output logic                    o_last_of_frame
);
  localparam int CELLS = IN_CHANNELS * OUT_CHANNELS;
  localparam int KW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int OAW   = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int NOUT  = (OUT_CHANNELS < rgmm_pkg::RESULT_CAP) ?
                         OUT_CHANNELS : rgmm_pkg::RESULT_CAP;
  localparam int XW    = $bits(rgmm_pkg::rgmm_xp_t);

  logic [1:0]         cmd_r;
  logic [2:0]         ich_r, och_r;
  logic [17:0]        val_r;
  logic signed [23:0] smp_r;
  logic               fend_r;
  logic [CW-1:0]      cnt_r;

  logic [17:0]        lvl_tgt_r;
  logic [33:0]        lvl_cur_r;
  logic signed [33:0] lvl_step_r;
  logic [15:0]        lvl_cnt_r;

  logic signed [42:0] prod_r;
  logic signed [50:0] hip_r;
  logic [33:0]        lop_r;

  logic               out_valid_r;
  logic [2:0]         out_dest_r;
  logic signed [23:0] out_smp_r;
  logic               out_last_r;

  // crosspoint store
  rgmm_pkg::rgmm_xp_t xp_q, xp_wd, xp_adv;
  logic [XW-1:0]      xp_rd;
  logic               xp_we;
  logic [CW-1:0]      col, k_full;
  logic [KW-1:0]      xp_addr;

  // accumulators
  logic [47:0]        acc_q, acc_wd;
  logic [47:0]        acc_rd;
  logic               acc_we;

  logic [33:0]        wide, cur_sel, quo;
  logic [34:0]        diff;
  logic [33:0]        mag;
  logic               neg, div_done;
  logic signed [33:0] qs;
  logic [15:0]        adv_cnt;
  logic signed [48:0] acc_sum;
  logic [47:0]        acc_sat;
  logic signed [50:0] x;
  logic signed [34:0] r;
  logic signed [23:0] r_sat;
  logic [17:0]        lvl_g;

  assign col     = (cmd_r == rgmm_pkg::CMD_GAIN) ? CW'(och_r) : cnt_r;
  assign k_full  = CW'(CW'(ich_r) * CW'(OUT_CHANNELS)) + col;
  assign xp_addr = ctl.clr_wr ? cnt_r[KW-1:0] : k_full[KW-1:0];
  assign xp_q    = rgmm_pkg::rgmm_xp_t'(xp_rd);
  assign acc_q   = acc_rd;

  rgmm_ram #(.WIDTH(XW), .DEPTH(CELLS)) u_xp_ram (
    .clk   (clk),
    .we    (xp_we),
    .waddr (xp_addr),
    .wdata (xp_wd),
    .raddr (xp_addr),
    .rdata (xp_rd)
  );

  rgmm_ram #(.WIDTH(48), .DEPTH(OUT_CHANNELS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (cnt_r[OAW-1:0]),
    .wdata (acc_wd),
    .raddr (cnt_r[OAW-1:0]),
    .rdata (acc_rd)
  );

  // ramp start: signed span divided by the step count
  assign wide    = {val_r, 16'b0};
  assign cur_sel = (cmd_r == rgmm_pkg::CMD_LEVEL) ? lvl_cur_r : xp_q.cur;
  assign diff    = {1'b0, wide} - {1'b0, cur_sel};
  assign neg     = diff[34];
  assign mag     = neg ? 34'(-diff) : diff[33:0];
  assign qs      = neg ? $signed(-quo) : $signed(quo);

  rgmm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (mag),
    .divisor  ((cmd_r == rgmm_pkg::CMD_LEVEL) ? level_steps : gain_steps),
    .done     (div_done),
    .quotient (quo)
  );

  // one ramp step of the crosspoint being read
  always_comb begin
    xp_adv  = xp_q;
    adv_cnt = xp_q.cnt - 16'd1;
    if (xp_q.cnt != '0) begin
      xp_adv.cnt = adv_cnt;
      if (adv_cnt != '0) begin
        xp_adv.cur = xp_q.cur + $unsigned(xp_q.step);
      end else begin
        xp_adv.cur = {xp_q.tgt, 16'b0};
      end
    end
  end

  always_comb begin
    xp_we = ctl.clr_wr | ctl.g_imm | ctl.g_div | ctl.s_adv;
    xp_wd = xp_adv;
    if (ctl.clr_wr) begin
      xp_wd = '0;
    end else if (ctl.g_imm) begin
      xp_wd = '{tgt: val_r, cur: wide, step: '0, cnt: '0};
    end else if (ctl.g_div) begin
      xp_wd = '{tgt: val_r, cur: xp_q.cur, step: qs, cnt: gain_steps};
    end
  end

  // accumulate with 48-bit saturation
  assign acc_sum = $signed({acc_q[47], acc_q}) + $signed({{6{prod_r[42]}}, prod_r});
  assign acc_sat = (acc_sum[48] != acc_sum[47]) ?
                   (acc_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : acc_sum[47:0];

  always_comb begin
    acc_we = ctl.s_acc | ctl.f_mul | (ctl.clr_wr & (32'(cnt_r) < OUT_CHANNELS));
    acc_wd = ctl.s_acc ? acc_sat : '0;
  end

  // output scaling: floor(acc * level / 2^32), accumulator split over hi and lo halves
  assign lvl_g = lvl_cur_r[33:16];
  assign x     = hip_r + $signed({17'b0, lop_r[33:16]});
  assign r     = x[50:16];
  always_comb begin
    if (!r[34] && (|r[33:23])) begin
      r_sat = 24'sh7FFFFF;
    end else if (r[34] && !(&r[33:23])) begin
      r_sat = -24'sh800000;
    end else begin
      r_sat = r[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lvl_tgt_r   <= rgmm_pkg::LEVEL_TGT_RST;
      lvl_cur_r   <= rgmm_pkg::LEVEL_CUR_RST;
      lvl_step_r  <= '0;
      lvl_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.cnt_clr) begin
        cnt_r <= '0;
      end else if (ctl.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (ctl.l_imm) begin
        lvl_tgt_r  <= val_r;
        lvl_cur_r  <= wide;
        lvl_step_r <= '0;
        lvl_cnt_r  <= '0;
      end else if (ctl.l_div) begin
        lvl_tgt_r  <= val_r;
        lvl_step_r <= qs;
        lvl_cnt_r  <= level_steps;
      end else if (ctl.l_adv && lvl_cnt_r != '0) begin
        lvl_cnt_r <= lvl_cnt_r - 16'd1;
        if (lvl_cnt_r != 16'd1) begin
          lvl_cur_r <= lvl_cur_r + $unsigned(lvl_step_r);
        end else begin
          lvl_cur_r <= {lvl_tgt_r, 16'b0};
        end
      end
      if (ctl.f_out) begin
        out_valid_r <= 1'b1;
      end else if (o_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r  <= i_command;
      ich_r  <= i_in_channel;
      och_r  <= i_out_channel;
      val_r  <= i_gain_value;
      smp_r  <= i_sample_in;
      fend_r <= i_frame_end;
    end
    if (ctl.s_adv) begin
      prod_r <= smp_r * $signed({1'b0, xp_adv.cur[33:16]});
    end
    if (ctl.f_mul) begin
      hip_r <= $signed(acc_q[47:16]) * $signed({1'b0, lvl_g});
      lop_r <= acc_q[15:0] * lvl_g;
    end
    if (ctl.f_out) begin
      out_dest_r <= cnt_r[2:0];
      out_smp_r  <= r_sat;
      out_last_r <= (32'(cnt_r) == NOUT - 1);
    end
  end

  always_comb begin
    st.cmd      = cmd_r;
    st.fend     = fend_r;
    st.ich_ok   = 32'(ich_r) < IN_CHANNELS;
    st.xp_ok    = (32'(ich_r) < IN_CHANNELS) && (32'(och_r) < OUT_CHANNELS);
    st.same_g   = xp_q.tgt == val_r;
    st.same_l   = lvl_tgt_r == val_r;
    st.zero_g   = gain_steps == '0;
    st.zero_l   = level_steps == '0;
    st.div_done = div_done;
    st.clr_last = 32'(cnt_r) == CELLS - 1;
    st.out_last = 32'(cnt_r) == OUT_CHANNELS - 1;
    st.emit     = 32'(cnt_r) < rgmm_pkg::RESULT_CAP;
    st.out_free = !out_valid_r || o_ready;
  end

  assign o_valid         = out_valid_r;
  assign o_dest_channel  = out_dest_r;
  assign o_sample_out    = out_smp_r;
  assign o_last_of_frame = out_last_r;
endmodule
`default_nettype wire

// ===== rtl/core/rgmm_ctrl.sv =====
// Controller state machine
`default_nettype none
module rgmm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rgmm_pkg::rgmm_st_t st,
  output rgmm_pkg::rgmm_ctl_t     ctl
);
  rgmm_pkg::rgmm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rgmm_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      rgmm_pkg::ST_CLEAR: begin
        ctl.clr_wr  = 1'b1;
        ctl.cnt_inc = 1'b1;
        if (st.clr_last) begin
          ctl.cnt_clr = 1'b1;
          state_nxt   = rgmm_pkg::ST_IDLE;
        end
      end
      rgmm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch   = 1'b1;
          ctl.cnt_clr = 1'b1;
          state_nxt   = rgmm_pkg::ST_DECODE;
        end
      end
      rgmm_pkg::ST_DECODE: begin
        priority if (st.cmd == rgmm_pkg::CMD_GAIN) begin
          state_nxt = st.xp_ok ? rgmm_pkg::ST_G_CHK : rgmm_pkg::ST_IDLE;
        end else if (st.cmd == rgmm_pkg::CMD_LEVEL) begin
          state_nxt = rgmm_pkg::ST_L_CHK;
        end else if (st.cmd == rgmm_pkg::CMD_SAMPLE) begin
          if (st.ich_ok) begin
            state_nxt = rgmm_pkg::ST_S_ADV;
          end else if (st.fend) begin
            state_nxt = rgmm_pkg::ST_F_LVL;
          end else begin
            state_nxt = rgmm_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = rgmm_pkg::ST_IDLE;
        end
      end
      rgmm_pkg::ST_G_CHK: begin
        priority if (st.same_g) begin
          state_nxt = rgmm_pkg::ST_IDLE;
        end else if (st.zero_g) begin
          ctl.g_imm = 1'b1;
          state_nxt = rgmm_pkg::ST_IDLE;
        end else begin
          ctl.div_start = 1'b1;
          state_nxt     = rgmm_pkg::ST_G_DIV;
        end
      end
      rgmm_pkg::ST_G_DIV: begin
        if (st.div_done) begin
          ctl.g_div = 1'b1;
          state_nxt = rgmm_pkg::ST_IDLE;
        end
      end
      rgmm_pkg::ST_L_CHK: begin
        priority if (st.same_l) begin
          state_nxt = rgmm_pkg::ST_IDLE;
        end else if (st.zero_l) begin
          ctl.l_imm = 1'b1;
          state_nxt = rgmm_pkg::ST_IDLE;
        end else begin
          ctl.div_start = 1'b1;
          state_nxt     = rgmm_pkg::ST_L_DIV;
        end
      end
      rgmm_pkg::ST_L_DIV: begin
        if (st.div_done) begin
          ctl.l_div = 1'b1;
          state_nxt = rgmm_pkg::ST_IDLE;
        end
      end
      rgmm_pkg::ST_S_RD: begin
        state_nxt = rgmm_pkg::ST_S_ADV;
      end
      rgmm_pkg::ST_S_ADV: begin
        ctl.s_adv = 1'b1;
        state_nxt = rgmm_pkg::ST_S_ACC;
      end
      rgmm_pkg::ST_S_ACC: begin
        ctl.s_acc   = 1'b1;
        ctl.cnt_inc = 1'b1;
        if (!st.out_last) begin
          state_nxt = rgmm_pkg::ST_S_RD;
        end else if (st.fend) begin
          state_nxt = rgmm_pkg::ST_F_LVL;
        end else begin
          state_nxt = rgmm_pkg::ST_IDLE;
        end
      end
      rgmm_pkg::ST_F_LVL: begin
        ctl.l_adv   = 1'b1;
        ctl.cnt_clr = 1'b1;
        state_nxt   = rgmm_pkg::ST_F_RD;
      end
      rgmm_pkg::ST_F_RD: begin
        state_nxt = rgmm_pkg::ST_F_MUL;
      end
      rgmm_pkg::ST_F_MUL: begin
        ctl.f_mul = 1'b1;
        state_nxt = rgmm_pkg::ST_F_SUM;
      end
      rgmm_pkg::ST_F_SUM: begin
        if (!st.emit || st.out_free) begin
          ctl.f_out   = st.emit;
          ctl.cnt_inc = 1'b1;
          state_nxt   = st.out_last ? rgmm_pkg::ST_IDLE : rgmm_pkg::ST_F_RD;
        end
      end
      default: state_nxt = rgmm_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/ramped_gain_mix_matrix.sv =====
// Input transfers: a command is decoded and checked (an ignored crosspoint stops there), and a
// ramp start runs the divider; a sample reads, advances and accumulates each crosspoint in turn.
// Frame end steps the level ramp, then reads, scales and emits results under back-pressure.
// One item in flight at a time; results leave through a one-entry output register.
// Reset (rst_n low, synchronous) starts a clearing pass over every crosspoint and
// accumulator RAM entry; no input transfer is taken until it ends.
`default_nettype none
`include "ramped_gain_mix_matrix_defines.svh"
module ramped_gain_mix_matrix #(
  parameter int IN_CHANNELS  = rgmm_pkg::IN_CHANNELS_DEF,
  parameter int OUT_CHANNELS = rgmm_pkg::OUT_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rgmm_in_if.sink          in_ch,
  rgmm_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam int NOUT = (OUT_CHANNELS < rgmm_pkg::RESULT_CAP) ?
                        OUT_CHANNELS : rgmm_pkg::RESULT_CAP;

  // ramp length registers; register index is paddr[2]
  logic [15:0] gain_steps_r, level_steps_r;
  logic        cfg_wr;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_steps_r  <= rgmm_pkg::RAMP_STEPS_RST;
      level_steps_r <= rgmm_pkg::RAMP_STEPS_RST;
    end else if (cfg_wr) begin
      if (32'(cfg_paddr[2]) == rgmm_pkg::REG_GAIN_STEPS) begin
        gain_steps_r <= cfg_pwdata[15:0];
      end else begin
        level_steps_r <= cfg_pwdata[15:0];
      end
    end
  end

  assign cfg_prdata = (32'(cfg_paddr[2]) == rgmm_pkg::REG_LEVEL_STEPS) ?
                      {16'b0, level_steps_r} : {16'b0, gain_steps_r};

  rgmm_pkg::rgmm_ctl_t ctl;
  rgmm_pkg::rgmm_st_t  st;
  logic                in_rdy;

  // sequencer: walks the output columns for each item
  rgmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .st       (st),
    .ctl      (ctl)
  );

  assign in_ch.ready = in_rdy;

  // datapath: crosspoint RAM, accumulator RAM, ramps, multipliers
  rgmm_dp #(
    .IN_CHANNELS  (IN_CHANNELS),
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .st              (st),
    .i_command       (in_ch.command),
    .i_in_channel    (in_ch.in_channel),
    .i_out_channel   (in_ch.out_channel),
    .i_gain_value    (in_ch.gain_value),
    .i_sample_in     (in_ch.sample_in),
    .i_frame_end     (in_ch.frame_end),
    .gain_steps      (gain_steps_r),
    .level_steps     (level_steps_r),
    .o_valid         (out_ch.valid),
    .o_ready         (out_ch.ready),
    .o_dest_channel  (out_ch.dest_channel),
    .o_sample_out    (out_ch.sample_out),
    .o_last_of_frame (out_ch.last_of_frame)
  );

  // in the cycle after an accepted transfer the block is busy and not ready
  `RGMM_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  // the frame's last result is the last emitted channel
  `RGMM_ASSERT_IMP(a_last_chan, out_ch.valid && out_ch.last_of_frame,
                   32'(out_ch.dest_channel) == NOUT - 1)
  // results only for existing channels
  `RGMM_ASSERT_IMP(a_dest_range, out_ch.valid, 32'(out_ch.dest_channel) < NOUT)
endmodule
`default_nettype wire
